// ===== design/dpb_pkg.sv =====
// shared types and constants for the depth pixel backprojection core
`timescale 1ns / 1ps
package dpb_pkg;

  localparam int unsigned DEPTH_MIN_Q = 41;
  localparam int unsigned DEPTH_MAX_Q = 40960;

  localparam logic [2:0] REG_RECIP_X = 3'd0;
  localparam logic [2:0] REG_RECIP_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_POSE_X = 3'd4;
  localparam logic [2:0] REG_POSE_Y = 3'd5;
  localparam logic [2:0] REG_POSE_Z = 3'd6;

  // kept pixel handed from the front to the back part
  typedef struct packed {
    logic [10:0] row;
    logic [10:0] col;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pix_t;

  typedef struct packed {
    logic [23:0] rfx;
    logic [23:0] rfy;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [63:0] prx;
    logic [63:0] pry;
    logic [63:0] prz;
  } cfg_t;

endpackage

// ===== design/dpb_regs.sv =====
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
module dpb_regs
  import dpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic [2:0] idx;
  logic wr;

  assign idx = paddr[5:3];
  assign wr = psel && penable && pwrite;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rfx <= 24'd8389;
      cfg_r.rfy <= 24'd8389;
      cfg_r.cx <= 16'd5120;
      cfg_r.cy <= 16'd3840;
      cfg_r.prx <= 64'd16384;
      cfg_r.pry <= 64'd1 << 30;
      cfg_r.prz <= 64'd1 << 46;
    end else if (wr) begin
      case (idx)
        REG_RECIP_X: cfg_r.rfx <= pwdata[23:0];
        REG_RECIP_Y: cfg_r.rfy <= pwdata[23:0];
        REG_CENTER_X: cfg_r.cx <= pwdata[15:0];
        REG_CENTER_Y: cfg_r.cy <= pwdata[15:0];
        REG_POSE_X: cfg_r.prx <= pwdata;
        REG_POSE_Y: cfg_r.pry <= pwdata;
        REG_POSE_Z: cfg_r.prz <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RECIP_X: prdata = {40'd0, cfg_r.rfx};
      REG_RECIP_Y: prdata = {40'd0, cfg_r.rfy};
      REG_CENTER_X: prdata = {48'd0, cfg_r.cx};
      REG_CENTER_Y: prdata = {48'd0, cfg_r.cy};
      REG_POSE_X: prdata = cfg_r.prx;
      REG_POSE_Y: prdata = cfg_r.pry;
      REG_POSE_Z: prdata = cfg_r.prz;
      default: prdata = 64'd0;
    endcase
  end

endmodule

// ===== design/dpb_front.sv =====
// front part: stride, bounds and depth window filter into a small queue
`timescale 1ns / 1ps
module dpb_front
  import dpb_pkg::*;
#(
  parameter int SAMPLE_STRIDE = 3,
  parameter int MAX_DIM = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pix_t        in_pix,
  output logic        q_valid,
  input  logic        q_ready,
  output pix_t        q_pix
);

  localparam int QD = 4;
  // reciprocal multiply gives the exact quotient for every 11-bit index
  localparam int RSH = 11 + $clog2(SAMPLE_STRIDE);
  localparam logic [12:0] RMUL = 13'((2 ** RSH + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE);

  pix_t mem_r [QD];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic keep, push, pop;
  logic [23:0] row_prod, col_prod;
  logic [10:0] row_quo, col_quo;
  logic [14:0] row_back, col_back;

  // index is on the stride when quotient times stride gives it back
  always_comb begin
    row_prod = {13'd0, in_pix.row} * {11'd0, RMUL};
    col_prod = {13'd0, in_pix.col} * {11'd0, RMUL};
    row_quo = 11'(row_prod >> RSH);
    col_quo = 11'(col_prod >> RSH);
    row_back = {4'd0, row_quo} * 15'(SAMPLE_STRIDE);
    col_back = {4'd0, col_quo} * 15'(SAMPLE_STRIDE);
    keep = (row_back == {4'd0, in_pix.row}) &&
           (col_back == {4'd0, in_pix.col}) &&
           (32'(in_pix.row) < MAX_DIM) && (32'(in_pix.col) < MAX_DIM) &&
           (32'(in_pix.depth) >= DEPTH_MIN_Q) && (32'(in_pix.depth) <= DEPTH_MAX_Q);
  end

  assign in_ready = (cnt_r != 3'(QD));
  assign push = in_valid && in_ready && keep;
  assign q_valid = (cnt_r != 3'd0);
  assign pop = q_valid && q_ready;
  assign q_pix = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'(QD))
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'(QD)) |-> !push) else $error("push into full queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 3'd1)) else $error("count mismatch");
`endif

endmodule

// ===== design/dpb_back.sv =====
// back part: pipelined back-projection and pose transform with a stallable output register
`timescale 1ns / 1ps
module dpb_back
  import dpb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  pix_t               q_pix,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic signed [23:0] out_z,
  output logic [7:0]         out_b,
  output logic [7:0]         out_g,
  output logic [7:0]         out_r
);

  localparam int NS = 5;

  logic [NS-1:0] v_r;
  logic adv;

  // stage 1: offsets and dx*depth
  logic signed [17:0] dx, dy;
  logic signed [34:0] pdx_r, pdy_r;
  logic [15:0] d1_r;
  logic [23:0] c1_r;
  // stage 2: times reciprocal, round
  logic signed [59:0] fx_full, fy_full;
  logic signed [31:0] camx_r, camy_r;
  logic [15:0] d2_r;
  logic [23:0] c2_r;
  // stage 3: nine rotation products
  logic signed [48:0] m_r [3][3];
  logic signed [34:0] t_r [3];
  logic [23:0] c3_r;
  // stage 4: sum and round
  logic signed [51:0] acc [3];
  logic signed [37:0] rnd_r [3];
  logic [23:0] c4_r;
  // stage 5: saturated output register
  logic signed [23:0] o_r [3];
  logic [23:0] c5_r;
  logic [63:0] prow [3];

  assign prow[0] = cfg.prx;
  assign prow[1] = cfg.pry;
  assign prow[2] = cfg.prz;

  // pipeline moves whenever the last stage is free or drained
  assign adv = !v_r[NS-1] || out_ready;
  assign q_ready = adv;
  assign out_valid = v_r[NS-1];
  assign out_x = o_r[0];
  assign out_y = o_r[1];
  assign out_z = o_r[2];
  assign out_b = c5_r[23:16];
  assign out_g = c5_r[15:8];
  assign out_r = c5_r[7:0];

  assign dx = $signed({3'd0, q_pix.col, 4'd0}) - $signed({2'd0, cfg.cx});
  assign dy = $signed({3'd0, q_pix.row, 4'd0}) - $signed({2'd0, cfg.cy});
  assign fx_full = pdx_r * $signed({1'b0, cfg.rfx}) + 60'sd134217728;
  assign fy_full = pdy_r * $signed({1'b0, cfg.rfy}) + 60'sd134217728;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 52'(m_r[i][0]) + 52'(m_r[i][1]) + 52'(m_r[i][2]) + 52'(t_r[i])
             + 52'sd8192;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], q_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pdx_r <= dx * $signed({1'b0, q_pix.depth});
      pdy_r <= dy * $signed({1'b0, q_pix.depth});
      d1_r <= q_pix.depth;
      c1_r <= {q_pix.blue, q_pix.green, q_pix.red};
      camx_r <= 32'(fx_full >>> 28);
      camy_r <= 32'(fy_full >>> 28);
      d2_r <= d1_r;
      c2_r <= c1_r;
      for (int i = 0; i < 3; i++) begin
        m_r[i][0] <= 49'($signed(prow[i][15:0]) * camx_r);
        m_r[i][1] <= 49'($signed(prow[i][31:16]) * camy_r);
        m_r[i][2] <= 49'($signed(prow[i][47:32]) * $signed({1'b0, d2_r}));
        t_r[i] <= 35'($signed(prow[i][63:48])) <<< 18;
        rnd_r[i] <= 38'(acc[i] >>> 14);
        if (rnd_r[i] > 38'sd8388607) o_r[i] <= 24'sd8388607;
        else if (rnd_r[i] < -38'sd8388608) o_r[i] <= -24'sd8388608;
        else o_r[i] <= rnd_r[i][23:0];
      end
      c3_r <= c2_r;
      c4_r <= c3_r;
      c5_r <= c4_r;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_x) && $stable(c5_r))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> q_ready) else $error("back part stalled while empty");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v_r[NS-2]) |=> out_valid) else $error("word lost in pipeline");
`endif

endmodule

// ===== design/depth_pixel_backprojection_core.sv =====
// depth pixel backprojection core: one pixel per clock, while in_ready is high, into a world-frame point
// path: each kept pixel passes through the filter queue and then the 5 pipeline stages
// throughput: one pixel per cycle while out_ready does not stall the output, set by the fully pipelined multiply stages
// the 4-entry queue lets the filter keep taking pixels while the output stalls
// synchronous active-low reset clears control state and loads identity pose defaults
`timescale 1ns / 1ps
module depth_pixel_backprojection_core
  import dpb_pkg::*;
#(
  parameter int SAMPLE_STRIDE = 3,
  parameter int MAX_DIM = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [10:0]        in_pixel_row,
  input  logic [10:0]        in_pixel_col,
  input  logic [15:0]        in_depth_q,
  input  logic [7:0]         in_blue,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_red,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_world_x,
  output logic signed [23:0] out_world_y,
  output logic signed [23:0] out_world_z,
  output logic [7:0]         out_point_blue,
  output logic [7:0]         out_point_green,
  output logic [7:0]         out_point_red,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  pix_t in_pix, q_pix;
  logic q_valid, q_ready;

  assign pready = 1'b1;
  assign in_pix = '{row: in_pixel_row, col: in_pixel_col, depth: in_depth_q,
                    blue: in_blue, green: in_green, red: in_red};

  dpb_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  dpb_front #(.SAMPLE_STRIDE(SAMPLE_STRIDE), .MAX_DIM(MAX_DIM)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_pix, .q_valid, .q_ready, .q_pix
  );

  dpb_back u_back (
    .clk, .rst_n, .cfg, .q_valid, .q_ready, .q_pix, .out_valid, .out_ready,
    .out_x(out_world_x), .out_y(out_world_y), .out_z(out_world_z),
    .out_b(out_point_blue), .out_g(out_point_green), .out_r(out_point_red)
  );

endmodule
